FILE: hw/rtl/ses_pkg.sv
package ses_pkg;

	localparam int VALUE_W = 32;

	// Gap sequence: g' = GAP_MUL * g + 1 while GAP_LIMIT * g <= count
	localparam int GAP_MUL   = 3;
	localparam int GAP_LIMIT = 9;

	// (g - 1) / 3 as a reciprocal multiply, exact for operands below 128
	localparam int DIV3_MUL   = 43;
	localparam int DIV3_SHIFT = 7;

	typedef enum logic [1:0] {
		WSEL_IN,
		WSEL_RD,
		WSEL_HELD
	} wsel_t;

	typedef struct packed {
		logic  wr_en;
		wsel_t wsel;
		logic  rd_en;
		logic  held_load;
		logic  res_load;
		logic  res_last;
		logic  res_dropped;
	} ses_cmd_t;

endpackage

FILE: hw/rtl/ses_datapath.sv
module ses_datapath
	import ses_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic signed [VALUE_W-1:0]   value,
	input  ses_cmd_t                    cmd,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	output logic                        gt,
	output logic signed [VALUE_W-1:0]   value_res,
	output logic                        last_res,
	output logic                        dropped
);

	logic signed [DATA_WIDTH-1:0] store_q [CAPACITY];
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic signed [DATA_WIDTH-1:0] held_q;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic signed [VALUE_W-1:0]    value_q;
	logic                         last_q;
	logic                         dropped_q;

	always_comb begin
		case (cmd.wsel)
			WSEL_IN:   wdata = DATA_WIDTH'(value);
			WSEL_RD:   wdata = rd_q;
			WSEL_HELD: wdata = held_q;
			default:   wdata = held_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			store_q[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.held_load) begin
			held_q <= rd_q;
		end
		if (cmd.res_load) begin
			value_q   <= VALUE_W'(rd_q);
			last_q    <= cmd.res_last;
			dropped_q <= cmd.res_dropped;
		end
	end

	assign gt        = rd_q > held_q;
	assign value_res = value_q;
	assign last_res  = last_q;
	assign dropped   = dropped_q;

endmodule

FILE: hw/rtl/ses_ctrl.sv
module ses_ctrl
	import ses_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	input  logic                        last,
	output logic                        ready,
	output logic                        res_valid,
	input  logic                        res_ready,
	input  logic                        gt,
	output ses_cmd_t                    cmd,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic [$clog2(CAPACITY)-1:0] rd_addr
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);

	typedef enum logic [2:0] {
		S_LOAD,
		S_GAP,
		S_IROW,
		S_IHELD,
		S_CMP,
		S_PUT,
		S_ORD,
		S_OWAIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] gap_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic          ovf_q;
	logic          res_valid_q;

	logic            accept;
	logic            full;
	logic [CW-1:0]   count_next;
	logic [CW+3:0]   gap_x9;
	logic [CW+1:0]   gap_up;
	logic [CW+5:0]   gap_div_prod;
	logic [CW-1:0]   gap_down;
	logic [CW-1:0]   j_dn;
	logic            slot_free;
	logic            k_final;

	assign ready      = (state_q == S_LOAD);
	assign accept     = valid && ready;
	assign full       = (count_q == CAP);
	assign count_next = full ? count_q : count_q + ONE;

	assign gap_x9       = (CW+4)'(gap_q) * (CW+4)'(GAP_LIMIT);
	assign gap_up       = (CW+2)'(gap_q) * (CW+2)'(GAP_MUL) + (CW+2)'(1);
	assign gap_div_prod = (CW+6)'(gap_q - ONE) * (CW+6)'(DIV3_MUL);
	assign gap_down     = CW'(gap_div_prod >> DIV3_SHIFT);

	assign j_dn      = j_q - gap_q;
	assign slot_free = !res_valid_q || res_ready;
	assign k_final   = (k_q + ONE == n_q);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.wsel        = WSEL_HELD;
		cmd.res_last    = k_final;
		cmd.res_dropped = ovf_q;
		wr_addr         = j_q[AW-1:0];
		rd_addr         = i_q[AW-1:0];
		case (state_q)
			S_LOAD: begin
				cmd.wr_en = accept && !full;
				cmd.wsel  = WSEL_IN;
				wr_addr   = count_q[AW-1:0];
			end
			S_IROW: begin
				cmd.rd_en = (i_q < n_q);
			end
			S_IHELD: begin
				cmd.held_load = 1'b1;
				cmd.rd_en     = 1'b1;
				rd_addr       = AW'(i_q - gap_q);
			end
			S_CMP: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = gt ? WSEL_RD : WSEL_HELD;
				cmd.rd_en = gt && (j_dn >= gap_q);
				rd_addr   = AW'(j_dn - gap_q);
			end
			S_PUT: begin
				cmd.wr_en = 1'b1;
			end
			S_ORD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = k_q[AW-1:0];
			end
			S_OWAIT: begin
				cmd.res_load = slot_free;
				cmd.rd_en    = slot_free && !k_final;
				rd_addr      = AW'(k_q + ONE);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			n_q         <= '0;
			gap_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						count_q <= count_next;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							n_q     <= count_next;
							gap_q   <= ONE;
							state_q <= S_GAP;
						end
					end
				end
				S_GAP: begin
					if (gap_x9 <= (CW+4)'(n_q)) begin
						gap_q <= CW'(gap_up);
					end else begin
						i_q     <= gap_q;
						state_q <= S_IROW;
					end
				end
				S_IROW: begin
					if (i_q < n_q) begin
						state_q <= S_IHELD;
					end else if (gap_q == ONE) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else begin
						gap_q <= gap_down;
						i_q   <= gap_down;
					end
				end
				S_IHELD: begin
					j_q     <= i_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (gt) begin
						// shift the larger element up one gap, keep walking down
						j_q <= j_dn;
						if (j_dn < gap_q) begin
							state_q <= S_PUT;
						end
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_IROW;
					end
				end
				S_PUT: begin
					i_q     <= i_q + ONE;
					state_q <= S_IROW;
				end
				S_ORD: begin
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					if (slot_free) begin
						k_q <= k_q + ONE;
						if (k_final) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/shell_sort_engine.sv
// Shellsort engine.
// Input channel (valid/ready, value, last): one signed word per transaction;
// the transaction with last high closes the set. Up to CAPACITY words are
// kept; further words of the same set are discarded and every result of
// that set carries dropped = 1.
// Result channel (res_valid/res_ready, value_res, last_res, dropped): the
// set in ascending order, last_res high on the final word.
// Loading accepts one word per cycle. After the closing word the sort runs on
// a store with one write port and one registered read port: the first gap is
// picked, then each gapped insertion step reads and holds the row element,
// shifts each larger element up one gap and writes the held element back.
// A stalled receiver holds the output register and freezes the drain; the
// input side stays closed until the last result is in the output register.
// Reset clears the word count, the overflow flag and the result valid flag;
// the element store and the result data register are not cleared.
module shell_sort_engine
	import ses_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      ready,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic signed [VALUE_W-1:0] value_res,
	output logic                      last_res,
	output logic                      dropped
);

	localparam int AW = $clog2(CAPACITY);

	ses_cmd_t      cmd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          gt;

	ses_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.last      (last),
		.ready     (ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.gt        (gt),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	ses_datapath #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.value     (value),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.gt        (gt),
		.value_res (value_res),
		.last_res  (last_res),
		.dropped   (dropped)
	);

endmodule

FILE: tb/tb_shell_sort_engine.sv
`timescale 1ns / 1ps

module tb_shell_sort_engine;
	import ses_pkg::*;

	localparam int CAPACITY = 64;
	localparam int HOLD_LEN = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int N_DIR = 23;

	typedef struct packed {
		logic [VALUE_W-1:0] row_value;
		logic               row_last;
		logic               row_typed;
		logic [VALUE_W-1:0] exp_value;
		logic               exp_last;
		logic               exp_dropped;
	} dir_row_t;

	typedef struct {
		logic signed [VALUE_W-1:0] word;
		logic                      fin;
		logic                      drop;
	} sorted_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;
	logic                      res_valid;
	logic                      res_ready;
	logic signed [VALUE_W-1:0] value_res;
	logic                      last_res;
	logic                      dropped;

	// shadow of the block's store, count and overflow flag
	logic signed [VALUE_W-1:0] shadow_store [CAPACITY];
	int                        shadow_count;
	bit                        shadow_overflow;
	sorted_word_t              sorted_q [$];

	int  errors;
	int  words_sent;
	int  sets_closed;
	int  words_checked;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;

	dir_row_t dir_rows [N_DIR] = '{
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
		'{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b1, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
		'{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b1, 1'b0},
		// duplicates and both extremes in one set
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'hffff_fffd, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		// reverse order, ten words: runs a gap of 4 before the final pass
		'{32'h0000_0009, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0008, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0006, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0004, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'haaaa_aaaa, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
	};

	shell_sort_engine #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(VALUE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid),
		.ready    (ready),
		.value    (value),
		.last     (last),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value_res(value_res),
		.last_res (last_res),
		.dropped  (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("shell_sort_engine regression: fail");
		$finish;
	end

	// Store one word; on a closing word, shellsort the set and queue it in order.
	function automatic void absorb_word(logic signed [VALUE_W-1:0] w, logic fin);
		int                        gap;
		int                        i;
		int                        j;
		int                        k;
		logic signed [VALUE_W-1:0] held;
		sorted_word_t              sw;
		if (shadow_count < CAPACITY) begin
			shadow_store[shadow_count] = w;
			shadow_count++;
		end else begin
			shadow_overflow = 1'b1;
		end
		if (!fin)
			return;
		gap = 1;
		while (gap <= shadow_count / 9)
			gap = 3 * gap + 1;
		for (; gap > 0; gap = gap / 3) begin
			for (i = gap; i < shadow_count; i++) begin
				held = shadow_store[i];
				j = i;
				while (j >= gap && shadow_store[j - gap] > held) begin
					shadow_store[j] = shadow_store[j - gap];
					j = j - gap;
				end
				shadow_store[j] = held;
			end
		end
		for (k = 0; k < shadow_count; k++) begin
			sw.word = shadow_store[k];
			sw.fin  = (k == shadow_count - 1);
			sw.drop = shadow_overflow;
			sorted_q.push_back(sw);
		end
		shadow_count = 0;
		shadow_overflow = 1'b0;
		sets_closed++;
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_word();
		logic signed [VALUE_W-1:0] w;
		case ($urandom_range(5))
			0: begin
				// narrow range to get plenty of equal values
				w = $urandom_range(8);
				w = w - 4;
			end
			1: w = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Offer one transaction and hold it until accepted.
	task automatic send_word(input logic signed [VALUE_W-1:0] w, input logic fin,
			input logic typed, input logic signed [VALUE_W-1:0] ev, input logic el,
			input logic ed);
		int           gap;
		sorted_word_t sw;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		value <= w;
		last  <= fin;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		words_sent++;
		absorb_word(w, fin);
		if (typed) begin
			void'(sorted_q.pop_back());
			sw.word = ev;
			sw.fin  = el;
			sw.drop = ed;
			sorted_q.push_back(sw);
		end
	endtask

	task automatic send_set(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_word(rand_word(), k == n - 1, 1'b0, '0, 1'b0, 1'b0);
	endtask

	task automatic send_random_sets(input int min_words);
		int n;
		int total;
		total = 0;
		while (total < min_words) begin
			n = ($urandom_range(5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			send_set(n);
			total += n;
		end
	endtask

	task automatic wait_drained();
		valid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_result();
		sorted_word_t sw;
		if (sorted_q.size() == 0) begin
			$display("%0t: unexpected result value_res=%0d last_res=%0b dropped=%0b",
				$time, value_res, last_res, dropped);
			errors++;
			return;
		end
		sw = sorted_q.pop_front();
		words_checked++;
		if (value_res !== sw.word) begin
			$display("%0t: value_res expected %0d actual %0d", $time, sw.word, value_res);
			errors++;
		end
		if (last_res !== sw.fin) begin
			$display("%0t: last_res expected %0b actual %0b", $time, sw.fin, last_res);
			errors++;
		end
		if (dropped !== sw.drop) begin
			$display("%0t: dropped expected %0b actual %0b", $time, sw.drop, dropped);
			errors++;
		end
	endtask

	// Result side: check each transaction, stall at random, honor a hold-off request.
	initial begin
		int hold_left;
		hold_left = 0;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				check_result();
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int r;
		errors = 0;
		words_sent = 0;
		sets_closed = 0;
		words_checked = 0;
		shadow_count = 0;
		shadow_overflow = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		valid = 1'b0;
		value = '0;
		last = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (r = 0; r < N_DIR; r++)
			send_word(dir_rows[r].row_value, dir_rows[r].row_last, dir_rows[r].row_typed,
				dir_rows[r].exp_value, dir_rows[r].exp_last, dir_rows[r].exp_dropped);
		wait_drained();

		// a set that exactly fills the store, sender mostly idle
		send_idle_pct = 84;
		send_set(CAPACITY);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 84;
		send_random_sets(6);
		wait_drained();

		// oversize set: the closing word itself lands beyond capacity
		send_idle_pct = 18;
		recv_stall_pct = 18;
		send_set(CAPACITY + 1);
		wait_drained();

		// long receiver hold-off while the next set keeps knocking
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		send_set(4);
		send_set(3);
		wait_drained();

		$display("sent %0d words in %0d sets, checked %0d sorted words", words_sent,
			sets_closed, words_checked);
		$display("covered extremes, duplicates, a full store, an oversize set and a long stall");
		if (errors == 0)
			$display("shell_sort_engine regression: pass");
		else
			$display("shell_sort_engine regression: fail");
		$finish;
	end

endmodule
